### hw/rtl/sdr_pkg.sv
package sdr_pkg;

  localparam int DUTY_FULL_DEF = 10000;
  localparam int MID_DUTY_DEF  = 750;

  localparam int DUTY_W = 14;
  localparam int TICK_W = 16;
  localparam int ERR_W  = 15;

  // serial divider: quotient bits, partial remainder width, bit counter width
  localparam int QUO_W = DUTY_W;
  localparam int REM_W = TICK_W + 1;
  localparam int CNT_W = $clog2(QUO_W);

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic                start;
    logic [QUO_W-1:0]    dividend;
    logic [TICK_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [QUO_W-1:0]    quotient;
  } div_rsp_t;

endpackage

### hw/rtl/sdr_in_if.sv
interface sdr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [sdr_pkg::DUTY_W-1:0]    target_duty;
  logic [sdr_pkg::TICK_W-1:0]    tick_count;

  modport source (output valid, operation, target_duty, tick_count, input ready);
  modport sink   (input valid, operation, target_duty, tick_count, output ready);
endinterface

### hw/rtl/sdr_out_if.sv
interface sdr_out_if;
  logic                          valid;
  logic                          ready;
  logic [sdr_pkg::DUTY_W-1:0]    duty_out;
  logic                          moving;

  modport source (output valid, duty_out, moving, input ready);
  modport sink   (input valid, duty_out, moving, output ready);
endinterface

### hw/rtl/sdr_div.sv
module sdr_div (
  input  logic              clk,
  input  logic              rst,
  input  sdr_pkg::div_req_t req,
  output sdr_pkg::div_rsp_t rsp
);

  localparam logic [sdr_pkg::CNT_W-1:0] LastBit = sdr_pkg::CNT_W'(sdr_pkg::QUO_W - 1);

  logic                          busy;
  logic                          done;
  logic [sdr_pkg::CNT_W-1:0]     cnt;
  logic [sdr_pkg::REM_W-1:0]     part;
  logic [sdr_pkg::QUO_W-1:0]     quo;
  logic [sdr_pkg::TICK_W-1:0]    dvs;

  logic [sdr_pkg::REM_W-1:0]     shifted;
  logic                          fits;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {part[sdr_pkg::REM_W-2:0], quo[sdr_pkg::QUO_W-1]};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LastBit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      part <= '0;
      quo  <= req.dividend;
      dvs  <= req.divisor;
    end else if (busy) begin
      part <= fits ? (shifted - {1'b0, dvs}) : shifted;
      quo  <= {quo[sdr_pkg::QUO_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### hw/rtl/servo_duty_ramp.sv
// Linear duty ramp for a servo PWM. A start beat stores the target (saturated
// to DUTY_FULL-1) and the signed error to it, and divides the error by the
// tick count in a bit-serial divider, one quotient bit per cycle. Every beat
// returns one result beat in the next cycle: duty and moving flag. A tick
// beat does not use the divider, so ticks can be taken every cycle while the
// output side keeps up; after a start beat the input stays closed until the
// divider is done and all 14 quotient bits of the step have come out.
module servo_duty_ramp #(
  parameter int DUTY_FULL = sdr_pkg::DUTY_FULL_DEF,
  parameter int MID_DUTY  = sdr_pkg::MID_DUTY_DEF
) (
  input logic           clk,
  input logic           rst,
  sdr_in_if.sink        item,
  sdr_out_if.source     result
);

  localparam int DW = sdr_pkg::DUTY_W;
  localparam int EW = sdr_pkg::ERR_W;
  localparam logic [DW-1:0] DutyMax  = DW'(DUTY_FULL - 1);
  localparam logic [DW-1:0] DutyInit = DW'(MID_DUTY);

  sdr_pkg::state_t   state, state_next;
  sdr_pkg::div_req_t div_req;
  sdr_pkg::div_rsp_t div_rsp;

  logic [DW-1:0]        cur, cur_next;
  logic [DW-1:0]        goal, goal_next;
  logic signed [EW-1:0] step, step_next;
  logic signed [EW-1:0] rem, rem_next;
  logic                 active, active_next;
  logic                 err_pos, err_pos_next;
  logic                 out_valid;
  logic [DW-1:0]        out_duty;
  logic                 out_moving;

  logic                 take;
  logic                 is_start;
  logic [DW-1:0]        tgt;
  logic signed [EW-1:0] err;
  logic [DW-1:0]        err_mag;
  logic signed [EW:0]   rem_dec;
  logic                 finish;
  logic signed [EW+1:0] duty_sum;
  logic [DW-1:0]        q;
  logic signed [EW-1:0] q_signed;

  sdr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sdr_pkg::ST_IDLE: if (take && is_start) state_next = sdr_pkg::ST_DIV;
      sdr_pkg::ST_DIV:  if (div_rsp.done) state_next = sdr_pkg::ST_IDLE;
      default:          state_next = sdr_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    item.ready = 1'b0;
    case (state)
      sdr_pkg::ST_IDLE: item.ready = !out_valid || result.ready;
      sdr_pkg::ST_DIV:  item.ready = 1'b0;
      default:          item.ready = 1'b0;
    endcase
  end

  assign take     = item.valid && item.ready;
  assign is_start = item.operation == sdr_pkg::OP_START;

  // start arithmetic
  always_comb begin
    tgt     = (item.target_duty > DutyMax) ? DutyMax : item.target_duty;
    err     = EW'({1'b0, tgt}) - EW'({1'b0, cur});
    err_mag = err[EW-1] ? DW'(-err) : DW'(err);
  end

  assign div_req.start    = take && is_start;
  assign div_req.dividend = err_mag;
  assign div_req.divisor  = (item.tick_count == '0) ? sdr_pkg::TICK_W'(1) : item.tick_count;

  // tick arithmetic
  always_comb begin
    rem_dec  = (EW+1)'(rem) - (EW+1)'(step);
    finish   = (step[EW-1] && !rem_dec[EW]) ||
               (!step[EW-1] && step != '0 && (rem_dec[EW] || rem_dec == '0));
    duty_sum = (EW+2)'(signed'({1'b0, cur})) + (EW+2)'(step);
  end

  // quotient back to a signed step; zero becomes one toward the target
  always_comb begin
    q        = div_rsp.quotient;
    q_signed = err_pos ? EW'({1'b0, q}) : -EW'({1'b0, q});
  end

  always_comb begin
    cur_next     = cur;
    goal_next    = goal;
    step_next    = step;
    rem_next     = rem;
    active_next  = active;
    err_pos_next = err_pos;

    if (take && is_start) begin
      goal_next    = tgt;
      rem_next     = err;
      active_next  = 1'b1;
      err_pos_next = !err[EW-1] && err != '0;
    end else if (take && active) begin
      if (finish) begin
        active_next = 1'b0;
        rem_next    = '0;
        cur_next    = goal;
      end else begin
        rem_next = rem_dec[EW-1:0];
        if (duty_sum[EW+1])
          cur_next = '0;
        else if (duty_sum > (EW+2)'({1'b0, DutyMax}))
          cur_next = DutyMax;
        else
          cur_next = duty_sum[DW-1:0];
      end
    end

    if (state == sdr_pkg::ST_DIV && div_rsp.done) begin
      if (q == '0)
        step_next = err_pos ? EW'(1) : -EW'(1);
      else
        step_next = q_signed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sdr_pkg::ST_IDLE;
      cur       <= DutyInit;
      goal      <= '0;
      step      <= '0;
      rem       <= '0;
      active    <= 1'b0;
      err_pos   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cur     <= cur_next;
      goal    <= goal_next;
      step    <= step_next;
      rem     <= rem_next;
      active  <= active_next;
      err_pos <= err_pos_next;
      // hold the result beat until taken
      if (take)
        out_valid <= 1'b1;
      else if (result.ready)
        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_duty   <= cur_next;
      out_moving <= active_next;
    end
  end

  assign result.valid    = out_valid;
  assign result.duty_out = out_duty;
  assign result.moving   = out_moving;

endmodule

### tb/sv/tb_servo_duty_ramp.sv
`timescale 1ns / 100ps

module tb_servo_duty_ramp;

  localparam int DUTY_FULL  = sdr_pkg::DUTY_FULL_DEF;
  localparam int MID_DUTY   = sdr_pkg::MID_DUTY_DEF;
  localparam int RANDOM_CMDS = 1200;
  localparam int QUIET_TAIL = 150;
  localparam int SQUEEZE_AT = 400;
  localparam int SQUEEZE_LEN = 300;

  typedef struct packed {
    logic                       op;
    logic [sdr_pkg::DUTY_W-1:0] target;
    logic [sdr_pkg::TICK_W-1:0] ticks;
  } ramp_cmd_t;

  typedef struct packed {
    logic [sdr_pkg::DUTY_W-1:0] duty;
    logic                       moving;
  } duty_result_t;

  logic clk = 1'b0;
  logic rst;

  sdr_in_if  cmd ();
  sdr_out_if rsp ();

  servo_duty_ramp #(
    .DUTY_FULL(DUTY_FULL),
    .MID_DUTY (MID_DUTY)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .item  (cmd),
    .result(rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ramp_cmd_t    cmd_q[$];
  duty_result_t due_duty_q[$];

  // shadow of the ramp state
  logic [sdr_pkg::DUTY_W-1:0]       ramp_duty;
  logic [sdr_pkg::DUTY_W-1:0]       ramp_goal;
  logic signed [sdr_pkg::ERR_W-1:0] ramp_step;
  logic signed [sdr_pkg::ERR_W-1:0] ramp_err;
  logic                             ramp_active;

  int fail_count = 0;
  int sent_count = 0;
  int got_count = 0;
  int quiet_mark = 0;
  int tx_gap;
  int rx_hold;
  bit squeeze_done = 1'b0;

  function automatic void log_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic void push_cmd(logic op, int tgt, int ticks);
    ramp_cmd_t c;
    c.op     = op;
    c.target = sdr_pkg::DUTY_W'(tgt);
    c.ticks  = sdr_pkg::TICK_W'(ticks);
    cmd_q.push_back(c);
  endfunction

  function automatic void push_junk_tick();
    push_cmd(sdr_pkg::OP_TICK, $urandom_range(0, 16383), $urandom_range(0, 65535));
  endfunction

  function automatic duty_result_t ramp_advance(ramp_cmd_t c);
    int tgt;
    int n;
    int q;
    int nxt;
    duty_result_t r;
    if (c.op == sdr_pkg::OP_START) begin
      tgt = int'(c.target);
      if (tgt > DUTY_FULL - 1) tgt = DUTY_FULL - 1;
      n = (c.ticks == 0) ? 1 : int'(c.ticks);
      ramp_goal = sdr_pkg::DUTY_W'(tgt);
      q = tgt - int'(ramp_duty);
      ramp_err = sdr_pkg::ERR_W'(q);
      q = q / n;
      if (q == 0) q = (q + int'(ramp_err) > 0) ? 1 : -1;
      ramp_step = sdr_pkg::ERR_W'(q);
      ramp_active = 1'b1;
    end else if (ramp_active) begin
      ramp_err = ramp_err - ramp_step;
      if ((ramp_step < 0 && ramp_err >= 0) || (ramp_step > 0 && ramp_err <= 0)) begin
        // error crossed zero: snap to the goal and stop
        ramp_active = 1'b0;
        ramp_err = '0;
        ramp_duty = ramp_goal;
      end else begin
        nxt = int'(ramp_duty) + int'(ramp_step);
        if (nxt < 0) nxt = 0;
        if (nxt > DUTY_FULL - 1) nxt = DUTY_FULL - 1;
        ramp_duty = sdr_pkg::DUTY_W'(nxt);
      end
    end
    r.duty = ramp_duty;
    r.moving = ramp_active;
    return r;
  endfunction

  // Driver: hold the beat until taken, then pick the next one or idle.
  always @(posedge clk) begin
    ramp_cmd_t c;
    if (rst) begin
      cmd.valid <= 1'b0;
      cmd.operation <= sdr_pkg::OP_TICK;
      cmd.target_duty <= '0;
      cmd.tick_count <= '0;
      tx_gap <= 0;
      ramp_duty = sdr_pkg::DUTY_W'(MID_DUTY);
      ramp_goal = '0;
      ramp_step = '0;
      ramp_err = '0;
      ramp_active = 1'b0;
    end else if (!cmd.valid || cmd.ready) begin
      if (cmd.valid) begin
        c.op = cmd.operation;
        c.target = cmd.target_duty;
        c.ticks = cmd.tick_count;
        due_duty_q.push_back(ramp_advance(c));
        sent_count++;
      end
      if (tx_gap > 0) begin
        cmd.valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (cmd_q.size() == 0) begin
        cmd.valid <= 1'b0;
      end else if (sent_count < quiet_mark && $urandom_range(0, 11) == 0) begin
        cmd.valid <= 1'b0;
        tx_gap <= $urandom_range(0, 14);
      end else begin
        c = cmd_q.pop_front();
        cmd.valid <= 1'b1;
        cmd.operation <= c.op;
        cmd.target_duty <= c.target;
        cmd.tick_count <= c.ticks;
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction.
  always @(posedge clk) begin
    duty_result_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got_count++;
        if (due_duty_q.size() == 0) begin
          log_fail($sformatf("unexpected result: duty %0d moving %0b",
                             rsp.duty_out, rsp.moving));
        end else begin
          want = due_duty_q.pop_front();
          if (rsp.duty_out !== want.duty || rsp.moving !== want.moving)
            log_fail($sformatf("result %0d: duty %0d moving %0b, expected duty %0d moving %0b",
                               got_count, rsp.duty_out, rsp.moving, want.duty, want.moving));
        end
      end
      if (rx_hold > 0) begin
        rsp.ready <= 1'b0;
        rx_hold <= rx_hold - 1;
      end else if (!squeeze_done && got_count >= SQUEEZE_AT) begin
        // long stall so the block backs up onto its input
        rsp.ready <= 1'b0;
        rx_hold <= SQUEEZE_LEN - 1;
        squeeze_done = 1'b1;
      end else if (got_count < quiet_mark && $urandom_range(0, 11) == 0) begin
        rsp.ready <= 1'b0;
        rx_hold <= $urandom_range(0, 14);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    int tgt;
    int ticks;
    int len;
    int base;
    rst = 1'b1;

    // directed: idle tick, full swings, saturated target, zero and max tick counts
    push_cmd(sdr_pkg::OP_TICK, 16383, 65535);
    push_cmd(sdr_pkg::OP_START, 0, 1);
    push_cmd(sdr_pkg::OP_TICK, 0, 0);
    push_cmd(sdr_pkg::OP_TICK, 0, 0);
    push_cmd(sdr_pkg::OP_START, 16383, 0);
    push_cmd(sdr_pkg::OP_TICK, 0, 0);
    push_cmd(sdr_pkg::OP_START, DUTY_FULL - 1, 65535);
    push_cmd(sdr_pkg::OP_TICK, 0, 0);
    push_cmd(sdr_pkg::OP_START, 0, 65535);
    repeat (3) push_cmd(sdr_pkg::OP_TICK, 0, 0);
    // replace the move while it runs
    push_cmd(sdr_pkg::OP_START, 5000, 3);
    repeat (4) push_cmd(sdr_pkg::OP_TICK, 0, 0);
    push_cmd(sdr_pkg::OP_START, DUTY_FULL - 2, 2);
    repeat (3) push_cmd(sdr_pkg::OP_TICK, 0, 0);
    push_cmd(sdr_pkg::OP_START, 1, 7);
    repeat (8) push_cmd(sdr_pkg::OP_TICK, 0, 0);

    base = cmd_q.size();
    while (cmd_q.size() < base + RANDOM_CMDS) begin
      if ($urandom_range(0, 9) < 8) begin
        tgt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383)
                                          : $urandom_range(0, DUTY_FULL - 1);
        if ($urandom_range(0, 5) == 0) begin
          ticks = $urandom_range(0, 65535);
          len = $urandom_range(1, 30);
        end else begin
          ticks = $urandom_range(0, 24);
          len = 2 * ticks + 3;
          if ($urandom_range(0, 3) == 0) len = $urandom_range(0, len);
        end
        push_cmd(sdr_pkg::OP_START, tgt, ticks);
        repeat (len) push_junk_tick();
      end else begin
        push_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 16383),
                 $urandom_range(0, 65535));
      end
    end
    quiet_mark = cmd_q.size() - QUIET_TAIL;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || cmd.valid || due_duty_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_servo_duty_ramp passed");
    end else begin
      $display("tb_servo_duty_ramp failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_servo_duty_ramp failed");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sdr_pkg.sv
hw/rtl/sdr_in_if.sv
hw/rtl/sdr_out_if.sv
hw/rtl/sdr_div.sv
hw/rtl/servo_duty_ramp.sv
tb/sv/tb_servo_duty_ramp.sv
